// File: src/wsft_pkg.sv
// Shared types, constants and helpers for the wildcard service filter table.
package wsft_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int MODE_W    = 2;
  localparam int SYS_W     = 16;
  localparam int PROV_W    = 24;
  localparam int SVC_W     = 16;
  localparam int COUNT_W   = 7;
  localparam int ENTRY_W   = SVC_W + PROV_W + SYS_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  localparam logic [SYS_W-1:0] SYS_FREE_A = 16'h0000;
  localparam logic [SYS_W-1:0] SYS_FREE_B = 16'hFFFF;
  localparam logic [SYS_W-1:0] SYS_ANY    = 16'hFFFE;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_free_sys(input logic [SYS_W-1:0] sys);
    return (sys == SYS_FREE_A) || (sys == SYS_FREE_B);
  endfunction

endpackage

// File: src/wsft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wsft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wsft_ctrl.sv
// Sequencing state machine: accept, table scan, result hand-off.
module wsft_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  wsft_pkg::dp_stat_t   stat_i,
  output wsft_pkg::ctrl_cmd_t  cmd_o
);
  import wsft_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    s_ready_o  = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/wsft_dp.sv
// Datapath: item register, entry count, table RAM, scan compare, output register.
module wsft_dp #(
  parameter int ENTRIES = wsft_pkg::ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wsft_pkg::ctrl_cmd_t              cmd_i,
  output wsft_pkg::dp_stat_t               stat_o,
  input  logic [wsft_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [wsft_pkg::OUT_DATA_W-1:0]  m_tdata_o
);
  import wsft_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  // input beat fields
  logic [MODE_W-1:0] in_mode;
  logic [SYS_W-1:0]  in_sys;
  logic [PROV_W-1:0] in_prov;
  logic [SVC_W-1:0]  in_svc;

  assign in_mode = s_tdata_i[1:0];
  assign in_sys  = s_tdata_i[17:2];
  assign in_prov = s_tdata_i[41:18];
  assign in_svc  = s_tdata_i[57:42];

  logic [MODE_W-1:0] mode_q;
  logic [SYS_W-1:0]  sys_q;
  logic [PROV_W-1:0] prov_q;
  logic [SVC_W-1:0]  svc_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_idx_q;
  logic          pend_q;
  logic          hit_q;
  logic          out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // table RAM, entry = {sys, prov, svc}
  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [SVC_W-1:0]   ent_svc;
  logic [PROV_W-1:0]  ent_prov;
  logic [SYS_W-1:0]   ent_sys;
  logic               ent_match;
  logic               more_to_issue;

  assign more_to_issue = (issue_idx_q < count_q);
  assign ram_re        = cmd_i.scan && more_to_issue;

  wsft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({sys_q, prov_q, svc_q}),
    .re_i    (ram_re),
    .raddr_i (issue_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_svc  = ram_rdata[SVC_W-1:0];
  assign ent_prov = ram_rdata[SVC_W+PROV_W-1:SVC_W];
  assign ent_sys  = ram_rdata[ENTRY_W-1:SVC_W+PROV_W];

  assign ent_match = (ent_svc == svc_q) &&
                     ((ent_sys == SYS_ANY) || (ent_sys == SYS_FREE_A) ||
                      ((ent_sys == sys_q) &&
                       ((ent_prov == '0) || (ent_prov == prov_q))));

  // status
  assign stat_o.need_scan = (mode_e'(in_mode) == MODE_CHECK) && (count_q != '0) &&
                            !is_free_sys(in_sys);
  assign stat_o.scan_done = cmd_i.scan &&
                            ((pend_q && ent_match) || (!pend_q && !more_to_issue));
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  // result of the held item
  logic ins_ok;
  logic allowed, stored, full;

  assign ins_ok = (svc_q != '0) && !is_free_sys(sys_q);

  always_comb begin
    allowed = 1'b0;
    stored  = 1'b0;
    full    = 1'b0;
    count_d = count_q;
    case (mode_e'(mode_q))
      MODE_CLEAR: begin
        count_d = '0;
      end
      MODE_INSERT: begin
        if (ins_ok) begin
          if (count_q < FULL_CNT) begin
            stored  = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            full = 1'b1;
          end
        end
      end
      MODE_CHECK: begin
        allowed = (count_q == '0) || is_free_sys(sys_q) || hit_q;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign ram_we = cmd_i.commit && stored;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode;
      sys_q  <= in_sys;
      prov_q <= in_prov;
      svc_q  <= in_svc;
    end
    if (cmd_i.commit) begin
      out_data_q <= {6'd0, COUNT_W'(count_d), full, stored, allowed};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        issue_idx_q <= '0;
        pend_q      <= 1'b0;
        hit_q       <= 1'b0;
      end else if (cmd_i.scan) begin
        // one read issued per cycle; its data compared in the next cycle
        pend_q <= more_to_issue;
        if (more_to_issue) begin
          issue_idx_q <= issue_idx_q + CW'(1);
        end
        if (pend_q && ent_match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

// File: src/wildcard_service_filter_table.sv
// Clear/insert go from the item register straight to the output register once it is
// free; a check with a non-empty table and a conditional system first scans the table,
// one table entry read per cycle from the single RAM read port (a match ends
// the scan early). One item is in work at a time; the next beat is taken once
// the result sits in the output register. Reset clears the count and control;
// table RAM contents are not initialized and are never read before written.
module wildcard_service_filter_table #(
  parameter int ENTRIES = wsft_pkg::ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // mode[1:0], ca_system[17:2], provider[41:18], service[57:42], zero pad
  input  logic [wsft_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // allowed[0], stored[1], table_full[2], entry_count[9:3], zero pad
  output logic [wsft_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import wsft_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  wsft_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wsft_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// File: src/wsft_checker.sv
// Port-level checks for the filter table, bound to the top level.
module wsft_checker #(
  parameter int ENTRIES = wsft_pkg::ENTRIES_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [wsft_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wsft_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import wsft_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(ENTRIES);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // a beat never sets more than one of allowed, stored and table_full
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
    else $error("more than one result flag set");

  // a dropped insert only happens at full count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[9:3] == FULL_CNT)
    else $error("table_full with count below capacity");

  // count never exceeds capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ENTRIES > 127) || (m_axis_tdata[9:3] <= FULL_CNT))
    else $error("entry_count above capacity");

  // one item in work at a time: no input beat right after an accept
  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

endmodule

bind wildcard_service_filter_table wsft_checker #(.ENTRIES(ENTRIES)) u_wsft_checker (.*);

// File: tb/wildcard_service_filter_table_tb.sv
// Testbench for wildcard_service_filter_table: directed table, then random clear/insert/check runs.
module wildcard_service_filter_table_tb;
  import wsft_pkg::*;

  localparam int N_ITEMS   = 1150;
  localparam int TBL_SLOTS = ENTRIES_DEF;
  localparam int REQ_W     = MODE_W + SYS_W + PROV_W + SVC_W;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYS_W-1:0]  ca_system;
    logic [PROV_W-1:0] provider;
    logic [SVC_W-1:0]  service;
  } filter_req_t;

  typedef struct packed {
    logic               allowed;
    logic               stored;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
  } filter_rsp_t;

  typedef struct packed {
    logic        known;  // rsp typed in; otherwise taken from the predictor
    filter_req_t req;
    filter_rsp_t rsp;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_TBL [N_DIR] = '{
    '{1'b1, '{MODE_CHECK,  16'h1234,   24'h00ABCD, 16'h0042}, '{1'b1, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_UNUSED, 16'hFFFF,   24'hFFFFFF, 16'hFFFF}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_INSERT, 16'h0100,   24'h000001, 16'h0000}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_INSERT, SYS_FREE_A, 24'h000010, 16'h0005}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_INSERT, SYS_FREE_B, 24'h000010, 16'h0005}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_INSERT, 16'h0100,   24'h000000, 16'h0001}, '{1'b0, 1'b1, 1'b0, 7'd1}},
    '{1'b1, '{MODE_INSERT, SYS_ANY,    24'hFFFFFF, 16'hFFFF}, '{1'b0, 1'b1, 1'b0, 7'd2}},
    '{1'b1, '{MODE_INSERT, 16'h0500,   24'h123456, 16'h0002}, '{1'b0, 1'b1, 1'b0, 7'd3}},
    '{1'b1, '{MODE_INSERT, 16'hFFFD,   24'hAAAAAA, 16'h5555}, '{1'b0, 1'b1, 1'b0, 7'd4}},
    '{1'b1, '{MODE_CHECK,  SYS_FREE_A, 24'h000000, 16'h9999}, '{1'b1, 1'b0, 1'b0, 7'd4}},
    '{1'b1, '{MODE_CHECK,  SYS_FREE_B, 24'hFFFFFF, 16'h0000}, '{1'b1, 1'b0, 1'b0, 7'd4}},
    // provider wildcard, any-system entry, exact hit, then near misses
    '{1'b0, '{MODE_CHECK,  16'h0100,   24'hFFFFFF, 16'h0001}, '0},
    '{1'b0, '{MODE_CHECK,  16'h0777,   24'h000000, 16'hFFFF}, '0},
    '{1'b0, '{MODE_CHECK,  16'h0500,   24'h123456, 16'h0002}, '0},
    '{1'b0, '{MODE_CHECK,  16'h0500,   24'h123457, 16'h0002}, '0},
    '{1'b0, '{MODE_CHECK,  16'h0600,   24'h123456, 16'h0002}, '0},
    '{1'b0, '{MODE_CHECK,  16'h0100,   24'h000000, 16'h0000}, '0},
    '{1'b0, '{MODE_CHECK,  16'hFFFD,   24'h555555, 16'h5555}, '0},
    '{1'b1, '{MODE_INSERT, 16'h0500,   24'h123456, 16'h0002}, '{1'b0, 1'b1, 1'b0, 7'd5}},
    '{1'b1, '{MODE_CLEAR,  16'hFFFF,   24'hFFFFFF, 16'hFFFF}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_CHECK,  16'h0500,   24'h123457, 16'h0002}, '{1'b1, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_UNUSED, 16'h0000,   24'h000000, 16'h0000}, '{1'b0, 1'b0, 1'b0, 7'd0}},
    '{1'b1, '{MODE_CLEAR,  16'h0000,   24'h000000, 16'h0000}, '{1'b0, 1'b0, 1'b0, 7'd0}}
  };

  localparam logic [SYS_W-1:0] SYS_POOL [4] = '{16'h0100, 16'h0500, 16'h0B00, 16'h1802};

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  wildcard_service_filter_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // predictor copy of the allow-list
  logic [SVC_W-1:0]  rule_svc  [TBL_SLOTS];
  logic [PROV_W-1:0] rule_prov [TBL_SLOTS];
  logic [SYS_W-1:0]  rule_sys  [TBL_SLOTS];
  int                rule_cnt = 0;

  filter_rsp_t pending_rsp_q [$];
  int items_sent = 0;
  int beats_seen = 0;
  int error_count = 0;
  int n_clear = 0, n_stored = 0, n_full = 0, n_allow = 0, n_deny = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int rx_stall = 0;
  filter_rsp_t got_rsp, want_rsp;

  function automatic logic sys_is_free(input logic [SYS_W-1:0] sys);
    return sys == SYS_FREE_A || sys == SYS_FREE_B;
  endfunction

  function automatic filter_rsp_t filter_table_step(input filter_req_t r);
    filter_rsp_t o;
    logic        hit;
    o = '0;
    case (r.mode)
      MODE_CLEAR: begin
        rule_cnt = 0;
        n_clear++;
      end
      MODE_INSERT: begin
        if (r.service != '0 && !sys_is_free(r.ca_system)) begin
          if (rule_cnt < TBL_SLOTS) begin
            rule_svc[rule_cnt]  = r.service;
            rule_prov[rule_cnt] = r.provider;
            rule_sys[rule_cnt]  = r.ca_system;
            rule_cnt++;
            o.stored = 1'b1;
            n_stored++;
          end else begin
            o.table_full = 1'b1;
            n_full++;
          end
        end
      end
      MODE_CHECK: begin
        hit = rule_cnt == 0 || sys_is_free(r.ca_system);
        for (int i = 0; i < rule_cnt; i++) begin
          if (rule_svc[i] == r.service) begin
            if (rule_sys[i] == SYS_ANY || rule_sys[i] == SYS_FREE_A) hit = 1'b1;
            if (rule_sys[i] == r.ca_system &&
                (rule_prov[i] == '0 || rule_prov[i] == r.provider)) hit = 1'b1;
          end
        end
        o.allowed = hit;
        if (hit) n_allow++;
        else n_deny++;
      end
      default: ;
    endcase
    o.entry_count = rule_cnt[COUNT_W-1:0];
    return o;
  endfunction

  task automatic send_item(input filter_req_t r, input logic known, input filter_rsp_t typed);
    int          gap;
    filter_rsp_t pred;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-REQ_W){1'b0}}, r.service, r.provider, r.ca_system, r.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = filter_table_step(r);
    pending_rsp_q.push_back(known ? typed : pred);
    items_sent++;
  endtask

  // hold off the sender until every outstanding beat has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  function automatic filter_req_t make_insert(input logic valid_only);
    filter_req_t r;
    int          pick;
    r.mode = MODE_INSERT;
    pick = $urandom_range(0, 7);
    if (pick < 4) r.ca_system = SYS_POOL[pick];
    else if (pick == 5) r.ca_system = SYS_ANY;
    else r.ca_system = 16'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 3))
      0:       r.provider = '0;
      1:       r.provider = 24'($urandom_range(1, 4));
      default: r.provider = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    r.service = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 24))
                                            : 16'($urandom_range(0, 16'hFFFF));
    if (valid_only) begin
      if (r.service == '0) r.service = 16'h0001;
      if (sys_is_free(r.ca_system)) r.ca_system = SYS_POOL[0];
    end else if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       r.service = '0;
        1:       r.ca_system = SYS_FREE_A;
        default: r.ca_system = SYS_FREE_B;
      endcase
    end
    return r;
  endfunction

  function automatic filter_req_t make_check();
    filter_req_t r;
    int          k;
    r.mode = MODE_CHECK;
    if (rule_cnt > 0 && $urandom_range(0, 4) != 0) begin
      // start from a held entry so that hits are common, then perturb it
      k = $urandom_range(0, rule_cnt - 1);
      r.ca_system = rule_sys[k];
      r.provider  = rule_prov[k];
      r.service   = rule_svc[k];
      if ($urandom_range(0, 2) == 0)
        r.provider = $urandom_range(0, 1) ? r.provider + 24'd1
                                          : 24'($urandom_range(0, 24'hFFFFFF));
      if ($urandom_range(0, 3) == 0) r.ca_system = SYS_POOL[$urandom_range(0, 3)];
      if ($urandom_range(0, 7) == 0) r.service = r.service + 16'd1;
      if ($urandom_range(0, 11) == 0)
        r.ca_system = $urandom_range(0, 1) ? SYS_FREE_A : SYS_FREE_B;
    end else begin
      r.ca_system = $urandom_range(0, 1) ? SYS_POOL[$urandom_range(0, 3)]
                                         : 16'($urandom_range(0, 16'hFFFF));
      r.provider  = 24'($urandom_range(0, 24'hFFFFFF));
      r.service   = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 24))
                                                : 16'($urandom_range(0, 16'hFFFF));
    end
    return r;
  endfunction

  task automatic random_phase(input logic fill);
    filter_req_t r;
    int          n_ins, n_chk;
    tx_calm = $urandom_range(0, 3) == 0;
    rx_calm = $urandom_range(0, 3) == 0;
    if (fill || $urandom_range(0, 2) == 0) begin
      r = {MODE_CLEAR, 16'($urandom()), 24'($urandom()), 16'($urandom())};
      send_item(r, 1'b0, '0);
    end
    if (fill) begin
      // run to capacity or past it, then an invalid triple against the full table
      n_ins = $urandom_range(TBL_SLOTS, TBL_SLOTS + 6);
      repeat (n_ins) send_item(make_insert(1'b1), 1'b0, '0);
      r = make_insert(1'b1);
      r.service = '0;
      send_item(r, 1'b0, '0);
      n_ins = 0;
    end else begin
      n_ins = $urandom_range(1, 12);
    end
    n_chk = $urandom_range(4, 20);
    while (n_ins + n_chk > 0) begin
      if ($urandom_range(0, 59) == 0) begin
        r = {MODE_UNUSED, 16'($urandom()), 24'($urandom()), 16'($urandom())};
        send_item(r, 1'b0, '0);
      end else if (n_ins > 0 && (n_chk == 0 || $urandom_range(0, 1) == 0)) begin
        send_item(make_insert(1'b0), 1'b0, '0);
        n_ins--;
      end else begin
        send_item(make_check(), 1'b0, '0);
        n_chk--;
      end
    end
  endtask

  // result side: score each beat, then draw a stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      got_rsp = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[9:3]};
      if (pending_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (got_rsp !== want_rsp) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch beat %0d: allowed %b/%b stored %b/%b full %b/%b count %0d/%0d",
                     beats_seen, want_rsp.allowed, got_rsp.allowed, want_rsp.stored,
                     got_rsp.stored, want_rsp.table_full, got_rsp.table_full,
                     want_rsp.entry_count, got_rsp.entry_count);
        end
      end
      rx_stall = rx_calm ? 0 : $urandom_range(0, 19);
    end
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIR; i++) send_item(DIR_TBL[i].req, DIR_TBL[i].known, DIR_TBL[i].rsp);
    drain_results();
    phase = 0;
    while (items_sent < N_ITEMS) begin
      random_phase(phase == 0 || $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) drain_results();
      phase++;
    end
    drain_results();
    repeat (100) @(posedge clk_i);
    $display("%0d items in %0d phases, %0d result beats; %0d clears, %0d stored, %0d full drops",
             items_sent, phase, beats_seen, n_clear, n_stored, n_full);
    $display("checks: %0d allowed, %0d denied; %0d errors", n_allow, n_deny, error_count);
    if (error_count == 0) begin
      $display("wildcard_service_filter_table verification clean");
    end else begin
      $display("wildcard_service_filter_table verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", pending_rsp_q.size());
    $display("wildcard_service_filter_table verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/wsft_pkg.sv
src/wsft_ram.sv
src/wsft_ctrl.sv
src/wsft_dp.sv
src/wildcard_service_filter_table.sv
src/wsft_checker.sv
tb/wildcard_service_filter_table_tb.sv
